/* hw/rtl/hmbs_pkg.sv */
// ----------------------------------------------------------------------------
// hmbs_pkg
// Shared types and constants of the heightmap bilinear sampler: field widths,
// register indexes, the queue entry between front and back, and the
// fixed-point constants of the address reduction and the blend.
// ----------------------------------------------------------------------------
`default_nettype none

package hmbs_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int HEIGHT_W = 16;
    localparam int INDEX_W  = 16;
    localparam int DIM_W    = 9;
    localparam int FRAC_W   = 8;
    localparam int RES_W    = 18;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0]     DIM_RESET      = 9'd256;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;

    // linear store index and its reduction modulo the store size
    localparam int LIN_W       = 2 * DIM_W;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = LIN_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam int WORDS_W     = 25;
    localparam int QM_W        = Q_W + WORDS_W;

    // blend arithmetic
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam int HPROD_W  = HEIGHT_W + WEIGHT_W;
    localparam int TOP_W    = HEIGHT_W + FRAC_W;
    localparam int SUM_W    = 32;
    localparam int RES_SHIFT = 14;
    localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = 9'd256;
    localparam logic [SUM_W-1:0]    ROUND_C    = 32'd8192;

    // one axis of a sample coordinate, split into neighbours and fraction
    typedef struct packed {
        logic              in_map;
        logic [DIM_W-1:0]  lo;
        logic [DIM_W-1:0]  hi;
        logic [FRAC_W-1:0] frac;
    } axis_t;

    // classified item travelling from front to back
    typedef struct packed {
        logic                sample;
        logic                in_map;
        logic [DIM_W-1:0]    c0;
        logic [DIM_W-1:0]    c1;
        logic [DIM_W-1:0]    r0;
        logic [DIM_W-1:0]    r1;
        logic [FRAC_W-1:0]   xf;
        logic [FRAC_W-1:0]   yf;
        logic [INDEX_W-1:0]  widx;
        logic [HEIGHT_W-1:0] wdata;
    } entry_t;

    // per-stage sideband of the back pipeline
    typedef struct packed {
        logic              valid;
        logic              sample;
        logic              in_map;
        logic [FRAC_W-1:0] xf;
        logic [FRAC_W-1:0] yf;
    } side_t;

    // pending store write
    typedef struct packed {
        logic                en;
        logic [INDEX_W-1:0]  idx;
        logic [HEIGHT_W-1:0] data;
    } wr_t;

    // one result item
    typedef struct packed {
        logic             outside;
        logic [RES_W-1:0] height;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/hmbs_fifo.sv */
// ----------------------------------------------------------------------------
// hmbs_fifo
// Small register-based queue with push/full and pop/empty; the head entry
// is shown combinationally while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hmbs_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // handshake status
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hmbs_front.sv */
// ----------------------------------------------------------------------------
// hmbs_front
// Classifies an incoming item: a write passes its index and data, a sample
// is range-checked on both axes and split into neighbour columns/rows and
// 8-bit fractions, with the far neighbour clamped at the map edge.
// ----------------------------------------------------------------------------
`default_nettype none

module hmbs_front
    import hmbs_pkg::*;
(
    input  wire logic                op,
    input  wire logic [INDEX_W-1:0]  write_index,
    input  wire logic [HEIGHT_W-1:0] write_height,
    input  wire logic [COORD_W-1:0]  sample_x,
    input  wire logic [COORD_W-1:0]  sample_y,
    input  wire logic [DIM_W-1:0]    map_width,
    input  wire logic [DIM_W-1:0]    map_height,
    output entry_t                   entry
);

    // range check and neighbour split for one axis
    function automatic axis_t split_axis(input logic [COORD_W-1:0] c,
                                         input logic [DIM_W-1:0]   lim);
        logic [DIM_W:0] nxt;
        axis_t          a;
        // negative values, with the top bit set, are outside
        a.in_map = !c[COORD_W-1] &&
                   (c[COORD_W-2:0] < {6'd0, lim, 8'd0});
        a.lo     = c[FRAC_W +: DIM_W];
        nxt      = {1'b0, c[FRAC_W +: DIM_W]} + (DIM_W + 1)'(1);
        a.hi     = (nxt < {1'b0, lim}) ? nxt[DIM_W-1:0] : c[FRAC_W +: DIM_W];
        a.frac   = c[FRAC_W-1:0];
        return a;
    endfunction

    axis_t ax;
    axis_t ay;

    assign ax = split_axis(sample_x, map_width);
    assign ay = split_axis(sample_y, map_height);

    // queue entry
    always_comb
    begin
        entry.sample = (op == OP_SAMPLE);
        entry.in_map = ax.in_map && ay.in_map;
        entry.c0     = ax.lo;
        entry.c1     = ax.hi;
        entry.r0     = ay.lo;
        entry.r1     = ay.hi;
        entry.xf     = ax.frac;
        entry.yf     = ay.frac;
        entry.widx   = write_index;
        entry.wdata  = write_height;
    end

endmodule

`default_nettype wire

/* hw/rtl/hmbs_ram.sv */
// ----------------------------------------------------------------------------
// hmbs_ram
// Height store copy: one write port and two read ports with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hmbs_ram #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16,
    parameter int unsigned DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic [DW-1:0]      rdata_a,
    output logic [DW-1:0]      rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

/* hw/rtl/hmbs_back.sv */
// ----------------------------------------------------------------------------
// hmbs_back
// Execution pipeline: row base multiply, linear index, reduction modulo the
// store size, four-way store read, horizontal then vertical blend. Pulls
// from the front queue under a credit window so that every result it
// starts has a free slot in the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hmbs_back
    import hmbs_pkg::*;
#(
    parameter int unsigned MAP_WORDS = 65536
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [DIM_W-1:0] map_width,
    input  wire entry_t           head,
    input  wire logic             head_valid,
    output logic                  head_pop,
    input  wire logic             out_full,
    input  wire logic             res_taken,
    output logic                  res_push,
    output result_t               res
);

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [WORDS_W-1:0] WORDS_C    = WORDS_W'(MAP_WORDS);
    localparam logic [63:0]        RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(MAP_WORDS);
    localparam logic [RECIP_W-1:0] RECIP_C    = RECIP_FULL[RECIP_W-1:0];

    // credit window over results in flight and waiting
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic                take_sample;

    assign head_pop = head_valid && !out_full &&
                      (!head.sample || (credit_reg < CREDIT_W'(OUT_DEPTH)));
    assign take_sample = head_pop && head.sample;

    always_comb
    begin
        unique case ({take_sample, res_taken})
            2'b10:   credit_next = credit_reg + CREDIT_W'(1);
            2'b01:   credit_next = credit_reg - CREDIT_W'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // stage 1: popped entry
    logic   v1_reg;
    entry_t ent1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= head_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        ent1_reg <= head;
    end

    // stage 1 logic: row bases and write qualification
    logic [LIN_W-1:0] base0;
    logic [LIN_W-1:0] base1;
    side_t            side1;
    wr_t              wr1;

    assign base0 = LIN_W'(ent1_reg.r0) * LIN_W'(map_width);
    assign base1 = LIN_W'(ent1_reg.r1) * LIN_W'(map_width);

    always_comb
    begin
        side1.valid  = v1_reg;
        side1.sample = ent1_reg.sample;
        side1.in_map = ent1_reg.in_map;
        side1.xf     = ent1_reg.xf;
        side1.yf     = ent1_reg.yf;
        // writes beyond the store are dropped
        wr1.en       = v1_reg && !ent1_reg.sample &&
                       (WORDS_W'(ent1_reg.widx) < WORDS_C);
        wr1.idx      = ent1_reg.widx;
        wr1.data     = ent1_reg.wdata;
    end

    // sideband and write info along the pipeline
    side_t side_reg [2:8];
    wr_t   wr_reg   [2:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 2; s <= 8; s++)
            begin
                side_reg[s] <= '0;
            end
            for (int s = 2; s <= 5; s++)
            begin
                wr_reg[s] <= '0;
            end
        end
        else
        begin
            side_reg[2] <= side1;
            for (int s = 3; s <= 8; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            wr_reg[2] <= wr1;
            for (int s = 3; s <= 5; s++)
            begin
                wr_reg[s] <= wr_reg[s-1];
            end
        end
    end

    // stage 2: row bases and columns
    logic [LIN_W-1:0] base0_2_reg, base1_2_reg;
    logic [DIM_W-1:0] c0_2_reg, c1_2_reg;

    always_ff @(posedge clk)
    begin
        base0_2_reg <= base0;
        base1_2_reg <= base1;
        c0_2_reg    <= ent1_reg.c0;
        c1_2_reg    <= ent1_reg.c1;
    end

    // stage 3: four linear indexes (top-left, top-right, bottom-left, bottom-right)
    logic [LIN_W-1:0] lin3_reg [4];

    always_ff @(posedge clk)
    begin
        lin3_reg[0] <= base0_2_reg + LIN_W'(c0_2_reg);
        lin3_reg[1] <= base0_2_reg + LIN_W'(c1_2_reg);
        lin3_reg[2] <= base1_2_reg + LIN_W'(c0_2_reg);
        lin3_reg[3] <= base1_2_reg + LIN_W'(c1_2_reg);
    end

    // stage 4: quotient estimate by reciprocal multiply, low by at most one
    logic [LIN_W-1:0] lin4_reg [4];
    logic [Q_W-1:0]   q4_reg   [4];
    logic [PROD_W-1:0] qprod   [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            qprod[k] = PROD_W'(lin3_reg[k]) * PROD_W'(RECIP_C);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            lin4_reg[k] <= lin3_reg[k];
            q4_reg[k]   <= qprod[k][PROD_W-1:RECIP_SHIFT];
        end
    end

    // stage 5: remainder, below twice the store size
    logic [LIN_W-1:0] rem5_reg [4];
    logic [QM_W-1:0]  qm       [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            qm[k] = QM_W'(q4_reg[k]) * QM_W'(WORDS_C);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            rem5_reg[k] <= lin4_reg[k] - qm[k][LIN_W-1:0];
        end
    end

    // stage 6: final correction into store addresses
    logic [AW-1:0]       addr6_reg [4];
    logic                we6_reg;
    logic [AW-1:0]       waddr6_reg;
    logic [HEIGHT_W-1:0] wdata6_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (WORDS_W'(rem5_reg[k]) >= WORDS_C)
            begin
                addr6_reg[k] <= AW'(rem5_reg[k] - LIN_W'(WORDS_C));
            end
            else
            begin
                addr6_reg[k] <= AW'(rem5_reg[k]);
            end
        end
        waddr6_reg <= AW'(wr_reg[5].idx);
        wdata6_reg <= wr_reg[5].data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            we6_reg <= 1'b0;
        end
        else
        begin
            we6_reg <= wr_reg[5].en;
        end
    end

    // stage 7: store read, two identical copies with two read ports each
    logic [HEIGHT_W-1:0] h7 [4];

    hmbs_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW),
        .DW    (HEIGHT_W)
    ) u_ram_top (
        .clk     (clk),
        .we      (we6_reg),
        .waddr   (waddr6_reg),
        .wdata   (wdata6_reg),
        .raddr_a (addr6_reg[0]),
        .raddr_b (addr6_reg[1]),
        .rdata_a (h7[0]),
        .rdata_b (h7[1])
    );

    hmbs_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW),
        .DW    (HEIGHT_W)
    ) u_ram_bot (
        .clk     (clk),
        .we      (we6_reg),
        .waddr   (waddr6_reg),
        .wdata   (wdata6_reg),
        .raddr_a (addr6_reg[2]),
        .raddr_b (addr6_reg[3]),
        .rdata_a (h7[2]),
        .rdata_b (h7[3])
    );

    // stage 8: blend along columns
    logic [WEIGHT_W-1:0] wx0, wx1;
    logic [HPROD_W-1:0]  top_sum, bot_sum;
    logic [TOP_W-1:0]    top8_reg, bot8_reg;

    assign wx1 = WEIGHT_W'(side_reg[7].xf);
    assign wx0 = ONE_WEIGHT - wx1;
    assign top_sum = HPROD_W'(h7[0]) * HPROD_W'(wx0) + HPROD_W'(h7[1]) * HPROD_W'(wx1);
    assign bot_sum = HPROD_W'(h7[2]) * HPROD_W'(wx0) + HPROD_W'(h7[3]) * HPROD_W'(wx1);

    always_ff @(posedge clk)
    begin
        top8_reg <= top_sum[TOP_W-1:0];
        bot8_reg <= bot_sum[TOP_W-1:0];
    end

    // blend along rows, round and scale into the result queue
    logic [WEIGHT_W-1:0] wy0, wy1;
    logic [SUM_W-1:0]    vsum;

    assign wy1  = WEIGHT_W'(side_reg[8].yf);
    assign wy0  = ONE_WEIGHT - wy1;
    assign vsum = SUM_W'(top8_reg) * SUM_W'(wy0) + SUM_W'(bot8_reg) * SUM_W'(wy1) + ROUND_C;

    assign res_push = side_reg[8].valid && side_reg[8].sample;

    always_comb
    begin
        res.outside = !side_reg[8].in_map;
        res.height  = side_reg[8].in_map ? vsum[RES_SHIFT +: RES_W] : '0;
    end

endmodule

`default_nettype wire

/* hw/rtl/heightmap_bilinear_sampler.sv */
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Heightmap store, bilinear sampling at signed 16.8 fixed-point coordinates.
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps that rate for any mix of
// writes and samples while pop is held high. A write stores one 16-bit
// height and gives no result; a sample returns one 18-bit interpolated
// height, or zero with outside_map set when the coordinate leaves the map.
// On its way a sample passes a four-entry input queue, an eight-stage
// pipeline (row multiply, index, modulo reduction in three steps, store
// read, two blend steps) and a 16-entry result queue. The four neighbour
// reads per sample come from two copies of the store with two read ports
// each, written together. Up to 16 results may be in flight or waiting;
// with pop held high the block never stalls. Width and height must be
// written only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler
    import hmbs_pkg::*;
#(
    parameter int unsigned MAP_WORDS = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input queue side
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 op,
    input  wire logic [INDEX_W-1:0]   write_index,
    input  wire logic [HEIGHT_W-1:0]  write_height,
    input  wire logic [COORD_W-1:0]   sample_x,
    input  wire logic [COORD_W-1:0]   sample_y,
    // result queue side
    output logic                      empty,
    input  wire logic                 pop,
    output logic [RES_W-1:0]          height,
    output logic                      outside_map,
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    // configuration registers
    logic [DIM_W-1:0] map_width_reg;
    logic [DIM_W-1:0] map_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= DIM_RESET;
            map_height_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                REG_MAP_HEIGHT: map_height_reg <= cfg_data;
            endcase
        end
    end

    // front: classify the incoming item
    entry_t in_entry;

    hmbs_front u_front (
        .op           (op),
        .write_index  (write_index),
        .write_height (write_height),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .map_width    (map_width_reg),
        .map_height   (map_height_reg),
        .entry        (in_entry)
    );

    // queue between front and back
    logic   mid_empty;
    logic   mid_pop;
    entry_t mid_head;

    hmbs_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_entry),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_head),
        .empty (mid_empty)
    );

    // back: execution pipeline
    logic    res_push;
    result_t res;
    result_t out_head;
    logic    out_full;

    hmbs_back #(
        .MAP_WORDS (MAP_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .map_width  (map_width_reg),
        .head       (mid_head),
        .head_valid (!mid_empty),
        .head_pop   (mid_pop),
        .out_full   (out_full),
        .res_taken  (pop && !empty),
        .res_push   (res_push),
        .res        (res)
    );

    // result queue
    hmbs_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_head),
        .empty (empty)
    );

    assign height      = out_head.height;
    assign outside_map = out_head.outside;

endmodule

`default_nettype wire
